// ===== sv/wrbs_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and constants of the wake and retry boot sequencer
package wrbs_pkg;

	localparam logic [15:0] DEFAULT_PORT = 16'd3389;

	localparam logic [31:0] TIMEOUT_RST = 32'd60000;
	localparam logic [31:0] SEND_IVL_RST = 32'd400;
	localparam logic [31:0] PROBE_IVL_RST = 32'd2000;
	localparam logic [7:0] MAX_SENDS_RST = 8'd3;
	localparam logic [15:0] PROBE_PORT_RST = 16'd0;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_BOOT = 2'd1,
		PH_ON   = 2'd2,
		PH_FAIL = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_BOOTING = 3'd1,
		ERR_ON      = 3'd2,
		ERR_LINK    = 3'd3,
		ERR_ADDR    = 3'd4,
		ERR_IP      = 3'd5,
		ERR_TIMEOUT = 3'd6,
		ERR_SEND    = 3'd7
	} err_t;

	typedef enum logic {
		ACT_START = 1'b0,
		ACT_TICK  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		CST_OK      = 2'd0,
		CST_NO_ADDR = 2'd1,
		CST_BAD_IP  = 2'd2,
		CST_OTHER   = 2'd3
	} cfg_status_t;

	typedef enum logic [2:0] {
		REG_TIMEOUT    = 3'd0,
		REG_SEND_IVL   = 3'd1,
		REG_PROBE_IVL  = 3'd2,
		REG_MAX_SENDS  = 3'd3,
		REG_PROBE_PORT = 3'd4
	} reg_idx_t;

	typedef struct packed {
		action_t     action;
		logic [31:0] now_ms;
		logic        link_up;
		cfg_status_t config_status;
		logic        send_ok;
		logic        host_reachable;
	} cmd_t;

	typedef struct packed {
		logic [31:0] timeout_ms;
		logic [31:0] send_interval_ms;
		logic [31:0] probe_interval_ms;
		logic [7:0]  max_sends;
		logic [15:0] probe_port;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		err_t        err;
		logic [31:0] start_time;
		logic [31:0] last_send_time;
		logic [31:0] last_probe_time;
		logic        probed;
		logic [7:0]  send_count;
	} state_t;

	typedef struct packed {
		phase_t      phase;
		err_t        error_code;
		logic        accepted;
		logic        send_wake;
		logic        issue_probe;
		logic [15:0] probe_port_used;
		logic [7:0]  sends_done;
		logic        busy_res;
	} rsp_t;

endpackage

// ===== sv/wrbs_if.sv =====
`timescale 1ns / 1ps
// valid/ready channels for command items and result items
interface wrbs_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] now_ms;
	logic        link_up;
	logic [1:0]  config_status;
	logic        send_ok;
	logic        host_reachable;

	modport source (output valid, action, now_ms, link_up, config_status, send_ok,
		host_reachable, input ready);
	modport sink (input valid, action, now_ms, link_up, config_status, send_ok,
		host_reachable, output ready);
endinterface

interface wrbs_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  phase;
	logic [2:0]  error_code;
	logic        accepted;
	logic        send_wake;
	logic        issue_probe;
	logic [15:0] probe_port_used;
	logic [7:0]  sends_done;
	logic        busy_res;

	modport source (output valid, phase, error_code, accepted, send_wake, issue_probe,
		probe_port_used, sends_done, busy_res, input ready);
	modport sink (input valid, phase, error_code, accepted, send_wake, issue_probe,
		probe_port_used, sends_done, busy_res, output ready);
endinterface

// ===== sv/wrbs_step.sv =====
`timescale 1ns / 1ps
// next-state and result logic for one command item
module wrbs_step (
	input  wrbs_pkg::cmd_t   cmd,
	input  wrbs_pkg::cfg_t   cfg,
	input  wrbs_pkg::state_t cur,
	output wrbs_pkg::state_t nxt,
	output wrbs_pkg::rsp_t   rsp
);

	logic [31:0]  since_start;
	logic [31:0]  since_send;
	logic [31:0]  since_probe;
	logic         send_due;
	logic         probe_due;
	wrbs_pkg::err_t err_out;
	logic         acc;
	logic         sent;
	logic         probe;

	assign since_start = cmd.now_ms - cur.start_time;
	assign since_send = cmd.now_ms - cur.last_send_time;
	assign since_probe = cmd.now_ms - cur.last_probe_time;

	assign send_due = (cur.send_count < cfg.max_sends) &&
		((cur.send_count == 8'd0) || (since_send >= cfg.send_interval_ms));
	assign probe_due = !cur.probed || (since_probe >= cfg.probe_interval_ms);

	always_comb begin
		nxt = cur;
		err_out = wrbs_pkg::ERR_NONE;
		acc = 1'b0;
		sent = 1'b0;
		probe = 1'b0;
		if (cmd.action == wrbs_pkg::ACT_START) begin
			if (cur.phase == wrbs_pkg::PH_BOOT) begin
				err_out = wrbs_pkg::ERR_BOOTING;
				acc = 1'b1;
			end else if (cur.phase == wrbs_pkg::PH_ON) begin
				err_out = wrbs_pkg::ERR_ON;
				acc = 1'b1;
			end else if (!cmd.link_up) begin
				nxt.phase = wrbs_pkg::PH_FAIL;
				nxt.err = wrbs_pkg::ERR_LINK;
				err_out = wrbs_pkg::ERR_LINK;
			end else if (cmd.config_status != wrbs_pkg::CST_OK) begin
				nxt.phase = wrbs_pkg::PH_FAIL;
				// any other nonzero status counts as a bad ip
				nxt.err = (cmd.config_status == wrbs_pkg::CST_NO_ADDR) ?
					wrbs_pkg::ERR_ADDR : wrbs_pkg::ERR_IP;
				err_out = nxt.err;
			end else begin
				nxt.start_time = cmd.now_ms;
				nxt.last_send_time = 32'd0;
				nxt.last_probe_time = 32'd0;
				nxt.probed = 1'b0;
				nxt.send_count = 8'd0;
				nxt.phase = wrbs_pkg::PH_BOOT;
				nxt.err = wrbs_pkg::ERR_NONE;
				acc = 1'b1;
			end
		end else begin
			if (cur.phase == wrbs_pkg::PH_BOOT) begin
				if (!cmd.link_up) begin
					nxt.phase = wrbs_pkg::PH_FAIL;
					nxt.err = wrbs_pkg::ERR_LINK;
				end else if (since_start > cfg.timeout_ms) begin
					nxt.phase = wrbs_pkg::PH_FAIL;
					nxt.err = wrbs_pkg::ERR_TIMEOUT;
				end else begin
					if (send_due) begin
						sent = 1'b1;
						if (!cmd.send_ok) begin
							nxt.phase = wrbs_pkg::PH_FAIL;
							nxt.err = wrbs_pkg::ERR_SEND;
						end else begin
							nxt.send_count = cur.send_count + 8'd1;
							nxt.last_send_time = cmd.now_ms;
						end
					end
					// a failed send skips the probe
					if (!(send_due && !cmd.send_ok) && probe_due) begin
						nxt.probed = 1'b1;
						nxt.last_probe_time = cmd.now_ms;
						probe = 1'b1;
						if (cmd.host_reachable) begin
							nxt.phase = wrbs_pkg::PH_ON;
							nxt.err = wrbs_pkg::ERR_NONE;
						end
					end
				end
			end
			err_out = nxt.err;
		end
	end

	always_comb begin
		rsp.phase = nxt.phase;
		rsp.error_code = err_out;
		rsp.accepted = acc;
		rsp.send_wake = sent;
		rsp.issue_probe = probe;
		rsp.probe_port_used = (cfg.probe_port == 16'd0) ? wrbs_pkg::DEFAULT_PORT :
			cfg.probe_port;
		rsp.sends_done = nxt.send_count;
		rsp.busy_res = (nxt.phase == wrbs_pkg::PH_BOOT);
	end

endmodule

// ===== sv/wake_retry_boot_sequencer.sv =====
`timescale 1ns / 1ps
// top level of the wake and retry boot sequencer
// Powers on a remote host: a start item (action 0) moves the block from idle or failed
// into booting, and each tick item (action 1) then sends up to max_sends wake packets,
// probes the host at its interval and goes to on when the host answers, or to failed on
// link loss, timeout or a failed send. Every command item gives exactly one result item.
// An item is registered on entry in the input register, its step is evaluated
// combinationally against the sequencer state and the result lands in the result
// register; a new item is taken every cycle while the result side does not stall.
// Configuration registers are written through wr_en, wr_index and wr_data; the user must
// do so while no item is in flight (the block does not enforce it); probe_port 0 selects port 3389.
module wake_retry_boot_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [2:0]        wr_index,
	input  logic [31:0]       wr_data,
	wrbs_in_if.sink           cmd,
	wrbs_out_if.source        res
);

	wrbs_pkg::cfg_t   cfg_q;
	wrbs_pkg::state_t state_q;
	wrbs_pkg::state_t state_nxt;
	wrbs_pkg::cmd_t   cmd_s1;
	logic             valid_s1;
	wrbs_pkg::rsp_t   rsp_nxt;
	wrbs_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;
	logic             advance;
	logic             take;

	assign advance = valid_s1 && (!rsp_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign take = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ms <= wrbs_pkg::TIMEOUT_RST;
			cfg_q.send_interval_ms <= wrbs_pkg::SEND_IVL_RST;
			cfg_q.probe_interval_ms <= wrbs_pkg::PROBE_IVL_RST;
			cfg_q.max_sends <= wrbs_pkg::MAX_SENDS_RST;
			cfg_q.probe_port <= wrbs_pkg::PROBE_PORT_RST;
		end else if (wr_en) begin
			case (wrbs_pkg::reg_idx_t'(wr_index))
				wrbs_pkg::REG_TIMEOUT: cfg_q.timeout_ms <= wr_data;
				wrbs_pkg::REG_SEND_IVL: cfg_q.send_interval_ms <= wr_data;
				wrbs_pkg::REG_PROBE_IVL: cfg_q.probe_interval_ms <= wr_data;
				wrbs_pkg::REG_MAX_SENDS: cfg_q.max_sends <= wr_data[7:0];
				wrbs_pkg::REG_PROBE_PORT: cfg_q.probe_port <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.action <= wrbs_pkg::action_t'(cmd.action);
			cmd_s1.now_ms <= cmd.now_ms;
			cmd_s1.link_up <= cmd.link_up;
			cmd_s1.config_status <= wrbs_pkg::cfg_status_t'(cmd.config_status);
			cmd_s1.send_ok <= cmd.send_ok;
			cmd_s1.host_reachable <= cmd.host_reachable;
		end
	end

	wrbs_step u_step (
		.cmd (cmd_s1),
		.cfg (cfg_q),
		.cur (state_q),
		.nxt (state_nxt),
		.rsp (rsp_nxt)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= wrbs_pkg::PH_IDLE;
			state_q.err <= wrbs_pkg::ERR_NONE;
			state_q.start_time <= 32'd0;
			state_q.last_send_time <= 32'd0;
			state_q.last_probe_time <= 32'd0;
			state_q.probed <= 1'b0;
			state_q.send_count <= 8'd0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (res.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign res.valid = rsp_valid_q;
	assign res.phase = rsp_q.phase;
	assign res.error_code = rsp_q.error_code;
	assign res.accepted = rsp_q.accepted;
	assign res.send_wake = rsp_q.send_wake;
	assign res.issue_probe = rsp_q.issue_probe;
	assign res.probe_port_used = rsp_q.probe_port_used;
	assign res.sends_done = rsp_q.sends_done;
	assign res.busy_res = rsp_q.busy_res;

endmodule
